>>> sv/ole_pkg.sv
// Shared types and constants for the ordered list engine.
// Holds the item structs, command and status codes, and controller/datapath links.
// No dependencies.
package ole_pkg;

    // List capacity and derived widths
    localparam int CAPACITY = 16;
    localparam int LEN_W    = $clog2(CAPACITY + 1);
    localparam int IDX_W    = $clog2(CAPACITY);

    typedef logic [LEN_W-1:0] len_t;
    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [4:0]       cnt_t;

    // Command codes
    localparam logic [2:0] CMD_INS_FRONT = 3'd0;
    localparam logic [2:0] CMD_INS_BACK  = 3'd1;
    localparam logic [2:0] CMD_INS_AFTER = 3'd2;
    localparam logic [2:0] CMD_DEL_FRONT = 3'd3;
    localparam logic [2:0] CMD_DEL_BACK  = 3'd4;
    localparam logic [2:0] CMD_DEL_KEY   = 3'd5;

    // Status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_EMPTY     = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    typedef struct packed {
        logic [2:0]   cmd;
        logic signed [31:0] key;
        logic signed [31:0] value;
    } in_item_t;

    typedef struct packed {
        logic [1:0]   status;
        logic signed [31:0] removed_value;
        cnt_t         entry_count;
    } out_item_t;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic step;
        logic commit;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic needs_scan;
        logic hit;
        logic last;
    } dp_stat_t;

endpackage

>>> sv/ordered_list_engine_core.sv
// Top level of the ordered list engine: controller plus datapath.
// Depends on ole_pkg, ole_ctrl and ole_dp.
//
// Keeps an ordered list of up to 16 signed 32-bit entries and runs one command
// per item: insert front, back or after a key, delete front, back or a key.
// Each item yields one result with status, removed value and new entry count.
// Insert-after-key and delete-key walk the list from the front, examining one
// entry per step through a single read port of the entry cells; other commands
// go straight from load to commit. A result waiting
// in the output register does not block acceptance of the next item; only its
// commit waits for the register to drain.
module ordered_list_engine_core (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  ole_pkg::in_item_t  s_item,
    output logic               m_valid,
    input  logic               m_ready,
    output ole_pkg::out_item_t m_item
);

    ole_pkg::dp_cmd_t  dp_cmd;
    ole_pkg::dp_stat_t dp_stat;

    ole_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (dp_stat),
        .cmd     (dp_cmd)
    );

    ole_dp u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_item  (s_item),
        .cmd     (dp_cmd),
        .stat    (dp_stat),
        .m_item  (m_item)
    );

    // Never overwrite a result that has not been taken
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        dp_cmd.commit |-> (!m_valid || m_ready))
        else $error("result overwritten before it was taken");

    // A full report only comes from a list at capacity
    a_full_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_item.status == ole_pkg::ST_FULL) |->
        (m_item.entry_count == ole_pkg::cnt_t'(ole_pkg::CAPACITY)))
        else $error("full status with list below capacity");

    // An empty report only comes from an empty list
    a_empty_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_item.status == ole_pkg::ST_EMPTY) |->
        (m_item.entry_count == '0 && m_item.removed_value == '0))
        else $error("empty status with entries present");

endmodule

>>> sv/ole_ctrl.sv
// Controller for the ordered list engine: idle, key scan and commit sequencing.
// Also owns the result valid flag. Depends on ole_pkg.
module ole_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    input  ole_pkg::dp_stat_t stat,
    output ole_pkg::dp_cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SCAN   = 3'b010,
        S_COMMIT = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || m_ready;
    assign s_ready  = (state_reg == S_IDLE);
    assign m_valid  = out_valid_reg;

    // Sequence one item: load, optional scan, commit into the result register
    always_comb begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = stat.needs_scan ? S_SCAN : S_COMMIT;
                end
            end
            S_SCAN: begin
                cmd.step = 1'b1;
                if (stat.hit || stat.last) begin
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT: begin
                if (out_free) begin
                    cmd.commit     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

>>> sv/ole_dp.sv
// Datapath for the ordered list engine: entry cells, length, scan index, result.
// Entries shift up or down by one on insert or delete. Depends on ole_pkg.
module ole_dp (
    input  logic               aclk,
    input  logic               aresetn,
    input  ole_pkg::in_item_t  s_item,
    input  ole_pkg::dp_cmd_t   cmd,
    output ole_pkg::dp_stat_t  stat,
    output ole_pkg::out_item_t m_item
);

    logic signed [31:0] vals_reg [ole_pkg::CAPACITY];
    ole_pkg::len_t      len_reg, len_next;
    ole_pkg::idx_t      idx_reg;
    logic               found_reg;
    logic [2:0]         cmd_reg;
    logic signed [31:0] key_reg;
    logic signed [31:0] value_reg;
    ole_pkg::out_item_t out_reg;

    logic signed [31:0] rd_data;
    logic               is_empty;
    logic               is_full;
    logic               do_ins, do_del;
    ole_pkg::len_t      pos;
    logic [1:0]         st;
    logic signed [31:0] rem;

    assign is_empty = (len_reg == '0);
    assign is_full  = (len_reg == ole_pkg::len_t'(ole_pkg::CAPACITY));
    assign rd_data  = vals_reg[idx_reg];

    // Scan status for the controller
    always_comb begin
        stat.needs_scan = !is_empty &&
            ((s_item.cmd == ole_pkg::CMD_INS_AFTER && !is_full) ||
             (s_item.cmd == ole_pkg::CMD_DEL_KEY));
        stat.hit  = (rd_data == key_reg);
        stat.last = (ole_pkg::len_t'(idx_reg) + ole_pkg::len_t'(1) == len_reg);
    end

    // Decide the list operation at commit time
    always_comb begin
        do_ins = 1'b0;
        do_del = 1'b0;
        pos    = '0;
        st     = ole_pkg::ST_OK;
        rem    = '0;
        case (cmd_reg)
            ole_pkg::CMD_INS_FRONT, ole_pkg::CMD_INS_BACK, ole_pkg::CMD_INS_AFTER: begin
                if (is_full) begin
                    st = ole_pkg::ST_FULL;
                end else if (cmd_reg == ole_pkg::CMD_INS_FRONT || is_empty) begin
                    do_ins = 1'b1;
                end else if (cmd_reg == ole_pkg::CMD_INS_BACK) begin
                    do_ins = 1'b1;
                    pos    = len_reg;
                end else if (found_reg) begin
                    do_ins = 1'b1;
                    pos    = ole_pkg::len_t'(idx_reg) + ole_pkg::len_t'(1);
                end else begin
                    st = ole_pkg::ST_NOT_FOUND;
                end
            end
            ole_pkg::CMD_DEL_FRONT, ole_pkg::CMD_DEL_BACK, ole_pkg::CMD_DEL_KEY: begin
                if (is_empty) begin
                    st = ole_pkg::ST_EMPTY;
                end else if (cmd_reg != ole_pkg::CMD_DEL_KEY || found_reg) begin
                    do_del = 1'b1;
                    pos    = ole_pkg::len_t'(idx_reg);
                    rem    = rd_data;
                end else begin
                    st = ole_pkg::ST_NOT_FOUND;
                end
            end
            default: begin
                st = ole_pkg::ST_OK;
            end
        endcase
        len_next = len_reg;
        if (do_ins) begin
            len_next = len_reg + ole_pkg::len_t'(1);
        end else if (do_del) begin
            len_next = len_reg - ole_pkg::len_t'(1);
        end
    end

    // Entry cells: open a gap on insert, close it on delete
    always_ff @(posedge aclk) begin
        for (int i = 0; i < ole_pkg::CAPACITY; i++) begin
            if (cmd.commit && do_ins) begin
                if (ole_pkg::len_t'(i) == pos) begin
                    vals_reg[i] <= value_reg;
                end else if (ole_pkg::len_t'(i) > pos) begin
                    vals_reg[i] <= vals_reg[(i == 0) ? 0 : i - 1];
                end
            end else if (cmd.commit && do_del) begin
                if (ole_pkg::len_t'(i) >= pos) begin
                    vals_reg[i] <= vals_reg[(i == ole_pkg::CAPACITY - 1) ? i : i + 1];
                end
            end
        end
    end

    // Capture the item, advance the scan, hold the result
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg <= '0;
        end else if (cmd.commit) begin
            len_reg <= len_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            cmd_reg   <= s_item.cmd;
            key_reg   <= s_item.key;
            value_reg <= s_item.value;
            found_reg <= 1'b0;
            if (s_item.cmd == ole_pkg::CMD_DEL_BACK && !is_empty) begin
                idx_reg <= ole_pkg::idx_t'(len_reg - ole_pkg::len_t'(1));
            end else begin
                idx_reg <= '0;
            end
        end else if (cmd.step) begin
            if (stat.hit) begin
                found_reg <= 1'b1;
            end else if (!stat.last) begin
                idx_reg <= idx_reg + ole_pkg::idx_t'(1);
            end
        end
        if (cmd.commit) begin
            out_reg.status        <= st;
            out_reg.removed_value <= rem;
            out_reg.entry_count   <= ole_pkg::cnt_t'(len_next);
        end
    end

    assign m_item = out_reg;

endmodule
